// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pa_pkg.sv
package pa_pkg;

  localparam int AMP_WIDTH_DEF    = 16;
  localparam int PHASE_WIDTH_DEF  = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  localparam int GUARD_BITS      = 16;
  localparam int HEADROOM_BITS   = 4;
  localparam int ATAN_LEN        = 24;
  localparam int ANGLE_W         = 32;
  localparam int Z_W             = 34;
  localparam int STEP_W          = 5;
  localparam int GAIN_W          = 23;
  localparam int INV_GAIN2_SHIFT = 24;
  localparam logic [GAIN_W-1:0] INV_GAIN2 = 23'd6186701;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_SUB  = 2'd2
  } pa_cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] wave_amplitude;
    logic [15:0]        wave_period;
    logic [15:0]        wave_phase;
  } pa_in_t;

  typedef struct packed {
    logic signed [15:0] sum_amplitude;
    logic [15:0]        sum_phase;
    logic [15:0]        sum_period;
    logic               period_mismatch;
    logic               amp_saturated;
  } pa_out_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_CAPTURE,
    DP_LOAD,
    DP_MISMATCH,
    DP_ROT1_INIT,
    DP_ROT2_INIT,
    DP_STEP,
    DP_SUM,
    DP_ZERO,
    DP_VEC_INIT,
    DP_SCALE_LO,
    DP_SCALE_HI,
    DP_FINISH
  } pa_op_t;

  typedef struct packed {
    pa_op_t op;
    logic   out_load;
  } pa_ctrl_t;

  typedef struct packed {
    logic is_load;
    logic is_addsub;
    logic period_match;
    logic sum_zero;
    logic step_last;
  } pa_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_ROT1,
    S_ROT2_INIT,
    S_ROT2,
    S_SUM,
    S_VEC_INIT,
    S_VEC,
    S_SCALE_LO,
    S_SCALE_HI,
    S_FINISH,
    S_OUT
  } pa_state_t;

  // arctan(2^-i) as a 32-bit binary angle
  function automatic logic [ANGLE_W-1:0] atan_angle(input logic [STEP_W-1:0] i);
    logic [ANGLE_W-1:0] a;
    case (i)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/phasor_accumulator.sv
// Phasor accumulator: holds one sinusoid (signed Q8.8 amplitude, period, binary-angle
// phase) and takes one command per beat: load a wave, add a wave or subtract a wave
// of the same period; a period mismatch keeps the state and raises period_mismatch.
// Every beat gives one result beat with the stored wave after the command. A load,
// a mismatch or an unused command goes from the decision straight to the output
// state; an add or subtract runs two rotations and one vectoring pass in turn
// through the one shared CORDIC iteration unit, followed by a two-step split
// multiply for the gain correction; a sum of zero skips vectoring and multiply.
// One item is worked on at a time; the next is taken once the result sits in the
// output register, even while that result is still stalled.
module phasor_accumulator #(
  parameter int AMP_WIDTH    = pa_pkg::AMP_WIDTH_DEF,
  parameter int PHASE_WIDTH  = pa_pkg::PHASE_WIDTH_DEF,
  parameter int CORDIC_STEPS = pa_pkg::CORDIC_STEPS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wave_valid,
  output logic            wave_stall,
  input  pa_pkg::pa_in_t  wave_item,
  output logic            sum_valid,
  input  logic            sum_stall,
  output pa_pkg::pa_out_t sum_item
);
  import pa_pkg::*;

  pa_ctrl_t   ctrl;
  pa_status_t status;

  pa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .wave_valid (wave_valid),
    .wave_stall (wave_stall),
    .sum_valid  (sum_valid),
    .sum_stall  (sum_stall),
    .status     (status),
    .ctrl       (ctrl)
  );

  pa_datapath #(
    .AMP_WIDTH    (AMP_WIDTH),
    .PHASE_WIDTH  (PHASE_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .wave_item (wave_item),
    .status    (status),
    .sum_item  (sum_item)
  );

endmodule

// File: rtl/pa_ctrl.sv
`include "assert_macros.svh"

module pa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              wave_valid,
  output logic              wave_stall,
  output logic              sum_valid,
  input  logic              sum_stall,
  input  pa_pkg::pa_status_t status,
  output pa_pkg::pa_ctrl_t   ctrl
);
  import pa_pkg::*;

  pa_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sum_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.out_load) begin
        sum_valid <= 1'b1;
      end else if (!sum_stall) begin
        sum_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    ctrl.op       = DP_IDLE;
    ctrl.out_load = 1'b0;
    wave_stall    = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (wave_valid) begin
          ctrl.op    = DP_CAPTURE;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (status.is_load) begin
          ctrl.op    = DP_LOAD;
          state_next = S_OUT;
        end else if (status.is_addsub && !status.period_match) begin
          ctrl.op    = DP_MISMATCH;
          state_next = S_OUT;
        end else if (status.is_addsub) begin
          ctrl.op    = DP_ROT1_INIT;
          state_next = S_ROT1;
        end else begin
          state_next = S_OUT;
        end
      end
      S_ROT1: begin
        ctrl.op = DP_STEP;
        if (status.step_last) begin
          state_next = S_ROT2_INIT;
        end
      end
      S_ROT2_INIT: begin
        ctrl.op    = DP_ROT2_INIT;
        state_next = S_ROT2;
      end
      S_ROT2: begin
        ctrl.op = DP_STEP;
        if (status.step_last) begin
          state_next = S_SUM;
        end
      end
      S_SUM: begin
        ctrl.op    = DP_SUM;
        state_next = S_VEC_INIT;
      end
      S_VEC_INIT: begin
        if (status.sum_zero) begin
          ctrl.op    = DP_ZERO;
          state_next = S_OUT;
        end else begin
          ctrl.op    = DP_VEC_INIT;
          state_next = S_VEC;
        end
      end
      S_VEC: begin
        ctrl.op = DP_STEP;
        if (status.step_last) begin
          state_next = S_SCALE_LO;
        end
      end
      S_SCALE_LO: begin
        ctrl.op    = DP_SCALE_LO;
        state_next = S_SCALE_HI;
      end
      S_SCALE_HI: begin
        ctrl.op    = DP_SCALE_HI;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        ctrl.op    = DP_FINISH;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!sum_valid || !sum_stall) begin
          ctrl.out_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `PA_ASSERT_NOW(a_out_load_in_out, clk, rst, ctrl.out_load, state == S_OUT, "result beat loaded outside output state")
  `PA_ASSERT_NEXT(a_rot1_to_rot2, clk, rst, state == S_ROT1 && status.step_last, state == S_ROT2_INIT, "first rotation did not hand over")

endmodule

// File: rtl/pa_datapath.sv
`include "assert_macros.svh"

module pa_datapath #(
  parameter int AMP_WIDTH    = pa_pkg::AMP_WIDTH_DEF,
  parameter int PHASE_WIDTH  = pa_pkg::PHASE_WIDTH_DEF,
  parameter int CORDIC_STEPS = pa_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  pa_pkg::pa_ctrl_t   ctrl,
  input  pa_pkg::pa_in_t     wave_item,
  output pa_pkg::pa_status_t status,
  output pa_pkg::pa_out_t    sum_item
);
  import pa_pkg::*;

  localparam int DW     = AMP_WIDTH + GUARD_BITS + HEADROOM_BITS;
  localparam int NSTEP  = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int PS     = ANGLE_W - PHASE_WIDTH;
  localparam int HI_W   = DW - INV_GAIN2_SHIFT;
  localparam int MUL_W  = (HI_W > INV_GAIN2_SHIFT) ? HI_W : INV_GAIN2_SHIFT;
  localparam int PROD_W = MUL_W + GAIN_W;
  localparam int P_W    = DW + 1;
  localparam int AW     = P_W - GUARD_BITS;

  logic [1:0]             cap_cmd;
  logic [AMP_WIDTH-1:0]   cap_amp;
  logic [15:0]            cap_period;
  logic [PHASE_WIDTH-1:0] cap_phase;

  logic [AMP_WIDTH-1:0]   acc_amplitude;
  logic [PHASE_WIDTH-1:0] acc_phase;
  logic [15:0]            acc_period;
  logic                   mismatch;
  logic                   sat;

  logic signed [DW-1:0]   x, y, hold_x, hold_y;
  logic signed [Z_W-1:0]  z;
  logic                   vec_mode;
  logic                   half_turn;
  logic [STEP_W-1:0]      step;
  logic [PROD_W-1:0]      prod;
  logic [INV_GAIN2_SHIFT-1:0] lo_part;

  // rotation start point
  logic signed [DW-1:0]   rot_a, rot_x0, rot_x_init;
  logic [ANGLE_W-1:0]     rot_ang, rot_ang_adj;
  logic                   rot_flip;

  always_comb begin
    if (ctrl.op == DP_ROT1_INIT) begin
      rot_a   = DW'($signed(acc_amplitude));
      rot_ang = ANGLE_W'(acc_phase) << PS;
    end else begin
      rot_a   = (cap_cmd == CMD_SUB) ? -DW'($signed(cap_amp)) : DW'($signed(cap_amp));
      rot_ang = ANGLE_W'(cap_phase) << PS;
    end
    rot_x0      = rot_a <<< GUARD_BITS;
    rot_flip    = (rot_ang[ANGLE_W-1:ANGLE_W-2] == 2'b01) ||
                  (rot_ang[ANGLE_W-1:ANGLE_W-2] == 2'b10);
    rot_x_init  = rot_flip ? -rot_x0 : rot_x0;
    rot_ang_adj = rot_flip ? (rot_ang ^ {1'b1, {(ANGLE_W-1){1'b0}}}) : rot_ang;
  end

  // shared cordic iteration
  logic signed [DW-1:0]  xs, ys, x_step, y_step;
  logic signed [Z_W-1:0] atan_z, z_step;
  logic                  dir;

  always_comb begin
    xs     = x >>> step;
    ys     = y >>> step;
    atan_z = $signed(Z_W'(atan_angle(step)));
    dir    = vec_mode ? y[DW-1] : !z[Z_W-1];
    x_step = dir ? (x - ys) : (x + ys);
    y_step = dir ? (y + xs) : (y - xs);
    z_step = dir ? (z - atan_z) : (z + atan_z);
  end

  // magnitude scaling and final rounding
  logic [DW-1:0]      mag;
  logic [MUL_W-1:0]   mul_a;
  logic [PROD_W-1:0]  mul_prod;
  logic [P_W-1:0]     p_sum;
  logic [AW-1:0]      amp_full, amp_max;
  logic [ANGLE_W-1:0] ang;
  logic [ANGLE_W:0]   ang_rnd;
  logic [PHASE_WIDTH-1:0] phase_new;

  always_comb begin
    mag      = x[DW-1] ? '0 : x;
    mul_a    = (ctrl.op == DP_SCALE_HI) ? MUL_W'(mag[DW-1:INV_GAIN2_SHIFT])
                                        : MUL_W'(mag[INV_GAIN2_SHIFT-1:0]);
    mul_prod = PROD_W'(mul_a) * PROD_W'(INV_GAIN2);
    p_sum    = P_W'(prod) + P_W'(lo_part);
    amp_full = AW'(p_sum >> GUARD_BITS);
    amp_max  = AW'({1'b0, {(AMP_WIDTH-1){1'b1}}});
    ang      = {half_turn, {(ANGLE_W-1){1'b0}}} + z[ANGLE_W-1:0];
    ang_rnd  = (ANGLE_W+1)'(ang) + (ANGLE_W+1)'(1 << (PS - 1));
    phase_new = PHASE_WIDTH'(ang_rnd >> PS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_amplitude <= '0;
      acc_phase     <= '0;
      acc_period    <= '0;
      mismatch      <= 1'b0;
      sat           <= 1'b0;
    end else begin
      case (ctrl.op)
        DP_CAPTURE: begin
          mismatch <= 1'b0;
          sat      <= 1'b0;
        end
        DP_LOAD: begin
          acc_amplitude <= cap_amp;
          acc_phase     <= cap_phase;
          acc_period    <= cap_period;
        end
        DP_MISMATCH: begin
          mismatch <= 1'b1;
        end
        DP_ZERO: begin
          acc_amplitude <= '0;
          acc_phase     <= '0;
        end
        DP_FINISH: begin
          if (amp_full > amp_max) begin
            acc_amplitude <= AMP_WIDTH'(amp_max);
            sat           <= 1'b1;
          end else begin
            acc_amplitude <= AMP_WIDTH'(amp_full);
          end
          acc_phase <= phase_new;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      DP_CAPTURE: begin
        cap_cmd    <= wave_item.command;
        cap_amp    <= AMP_WIDTH'($unsigned(wave_item.wave_amplitude));
        cap_period <= wave_item.wave_period;
        cap_phase  <= PHASE_WIDTH'(wave_item.wave_phase);
      end
      DP_ROT1_INIT: begin
        x        <= rot_x_init;
        y        <= '0;
        z        <= Z_W'($signed(rot_ang_adj));
        vec_mode <= 1'b0;
        step     <= '0;
      end
      DP_ROT2_INIT: begin
        hold_x   <= x;
        hold_y   <= y;
        x        <= rot_x_init;
        y        <= '0;
        z        <= Z_W'($signed(rot_ang_adj));
        vec_mode <= 1'b0;
        step     <= '0;
      end
      DP_STEP: begin
        x    <= x_step;
        y    <= y_step;
        z    <= z_step;
        step <= step + 1'b1;
      end
      DP_SUM: begin
        hold_x <= hold_x + x;
        hold_y <= hold_y + y;
      end
      DP_VEC_INIT: begin
        x         <= hold_x[DW-1] ? -hold_x : hold_x;
        y         <= hold_x[DW-1] ? -hold_y : hold_y;
        z         <= '0;
        half_turn <= hold_x[DW-1];
        vec_mode  <= 1'b1;
        step      <= '0;
      end
      DP_SCALE_LO: begin
        prod <= mul_prod;
      end
      DP_SCALE_HI: begin
        // rounding constant folded into the low partial product
        lo_part <= INV_GAIN2_SHIFT'(prod >> INV_GAIN2_SHIFT) +
                   INV_GAIN2_SHIFT'(1 << (GUARD_BITS - 1));
        prod    <= mul_prod;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      sum_item.sum_amplitude   <= 16'(acc_amplitude);
      sum_item.sum_phase       <= 16'(acc_phase);
      sum_item.sum_period      <= acc_period;
      sum_item.period_mismatch <= mismatch;
      sum_item.amp_saturated   <= sat;
    end
  end

  always_comb begin
    status.is_load      = (cap_cmd == CMD_LOAD);
    status.is_addsub    = (cap_cmd == CMD_ADD) || (cap_cmd == CMD_SUB);
    status.period_match = (cap_period == acc_period);
    status.sum_zero     = (hold_x == '0) && (hold_y == '0);
    status.step_last    = (step == STEP_W'(NSTEP - 1));
  end

  `PA_ASSERT_NEXT(a_finish_nonneg, clk, rst, ctrl.op == DP_FINISH, !acc_amplitude[AMP_WIDTH-1], "summed amplitude came out negative")
  `PA_ASSERT_NEXT(a_load_flags, clk, rst, ctrl.op == DP_LOAD, !mismatch && !sat, "flag raised on a load")

endmodule
